[design/nq_pkg.sv]
// Shared constants and controller/datapath interface types for the N-queens search unit.
`default_nettype none
package nq_pkg;

  localparam int MAX_SIZE = 16;
  localparam int SIZE_W   = 5;
  localparam int COL_W    = 4;
  localparam int DIAG_W   = 2 * MAX_SIZE - 1;
  localparam int DIAG_IW  = $clog2(DIAG_W);
  localparam int SUM_W    = SIZE_W + 1;

  typedef struct packed {
    logic load;
    logic place;
    logic back;
    logic emit_row;
    logic emit_fail;
  } nq_cmd_t;

  typedef struct packed {
    logic size_ok;
    logic row_full;
    logic hit;
    logic row_zero;
    logic emit_last;
  } nq_stat_t;

endpackage
`default_nettype wire

[design/n_queens_first_solution_unit.sv]
// Top level of the N-queens first-solution search unit.
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one word, board_size_i (1..16).
//   A word is taken when in_valid_i is high and in_stall_o is low; in_stall_o
//   stays high from the accepting edge until the last result word is loaded
//   into the output register.
//   Output channel: out_valid_o / out_stall_i carry result words. A found
//   placement gives one word per row (row_index_o, queen_column_o), found_o
//   set and last_o on the final row. Sizes with no placement (2, 3) and sizes
//   of 0 or above 16 give one word with found_o clear and last_o set.
//   Order of work: the size is captured, then the search makes one step per
//   cycle (each placement or backtrack of one queen is one step), a further
//   step sees the full board, then one result word per cycle goes out while
//   the receiver takes them. The step count of the depth-first search depends
//   on the board size; a board of 16 is the worst.
//   One request is in work at a time; the next size is taken once the last
//   word sits in the output register, even while that word is still stalled.
//   Stalls on the output freeze emission; the output word holds steady.
//   Reset (rst_ni low, asynchronous) clears the masks, the control state and
//   the output valid; the column stack is written before it is ever read.
`default_nettype none
module n_queens_first_solution_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [nq_pkg::SIZE_W-1:0] board_size_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           found_o,
  output logic [nq_pkg::COL_W-1:0]       row_index_o,
  output logic [nq_pkg::COL_W-1:0]       queen_column_o,
  output logic                           last_o
);
  import nq_pkg::*;

  nq_cmd_t  cmd;
  nq_stat_t stat;

  // Sequencer: decides each cycle whether to place, backtrack or emit.
  nq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: masks, stack and the output word.
  nq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .board_size_i   (board_size_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .found_o        (found_o),
    .row_index_o    (row_index_o),
    .queen_column_o (queen_column_o),
    .last_o         (last_o)
  );

  // An accepted size keeps the input stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a size");

  // A not-found word is always a single, final, zeroed word.
  a_fail_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (last_o && row_index_o == '0 && queen_column_o == '0))
    else $error("malformed not-found word");

  // Rows of a placement follow one another without a gap.
  a_rows_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("gap between row words of one placement");

  // The search never accepts a new size while rows are pending.
  a_no_accept_midrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> in_stall_o)
    else $error("input open while a placement is being emitted");

endmodule
`default_nettype wire

[design/nq_ctrl.sv]
// Sequencer for the N-queens search: request intake, search steps and result emission.
`default_nettype none
module nq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire nq_pkg::nq_stat_t stat_i,
  output nq_pkg::nq_cmd_t       cmd_o
);
  import nq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_FAIL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!stat_i.size_ok) begin
          state_d = ST_FAIL;
        end else if (stat_i.row_full) begin
          state_d = ST_EMIT;
        end else if (stat_i.hit) begin
          cmd_o.place = 1'b1;
        end else if (stat_i.row_zero) begin
          state_d = ST_FAIL;
        end else begin
          cmd_o.back = 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit_row = 1'b1;
          out_valid_d    = 1'b1;
          if (stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FAIL: begin
        if (slot_free) begin
          cmd_o.emit_fail = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

[design/nq_dpath.sv]
// Search datapath: occupancy masks, column stack, free-column pick and output word registers.
`default_nettype none
module nq_dpath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [nq_pkg::SIZE_W-1:0] board_size_i,
  input  wire nq_pkg::nq_cmd_t           cmd_i,
  output nq_pkg::nq_stat_t               stat_o,
  output logic                           found_o,
  output logic [nq_pkg::COL_W-1:0]       row_index_o,
  output logic [nq_pkg::COL_W-1:0]       queen_column_o,
  output logic                           last_o
);
  import nq_pkg::*;

  logic [SIZE_W-1:0]   size_q;
  logic [SIZE_W-1:0]   row_q, row_d;
  logic [SIZE_W-1:0]   start_q, start_d;
  logic [MAX_SIZE-1:0] used_q, used_d;
  logic [DIAG_W-1:0]   down_q, down_d;
  logic [DIAG_W-1:0]   up_q, up_d;
  logic [COL_W-1:0]    stack_q [MAX_SIZE];
  logic [COL_W-1:0]    eidx_q;

  logic [MAX_SIZE-1:0] free_v;
  logic [SUM_W-1:0]    dsum, usum;
  logic [COL_W-1:0]    pick;
  logic [SIZE_W-1:0]   row_dec;
  logic [COL_W-1:0]    rd_addr, rd_col;
  logic [COL_W-1:0]    tg_row, tg_col;
  logic [SUM_W-1:0]    tg_dsum, tg_usum;
  logic                emit_last;

  // Free columns of the current row at or above the resume point.
  always_comb begin
    free_v = '0;
    dsum   = '0;
    usum   = '0;
    for (int c = 0; c < MAX_SIZE; c++) begin
      if ((c < int'(size_q)) && (c >= int'(start_q)) && (row_q < size_q)) begin
        dsum = SUM_W'(row_q) + SUM_W'(size_q) - SUM_W'(1) - SUM_W'(c);
        usum = SUM_W'(row_q) + SUM_W'(c);
        free_v[c] = !used_q[c] && !down_q[dsum[DIAG_IW-1:0]] && !up_q[usum[DIAG_IW-1:0]];
      end
    end
  end

  // Lowest free column wins.
  always_comb begin
    pick = '0;
    for (int c = MAX_SIZE - 1; c >= 0; c--) begin
      if (free_v[c]) begin
        pick = COL_W'(c);
      end
    end
  end

  assign row_dec = row_q - SIZE_W'(1);
  assign rd_addr = cmd_i.emit_row ? eidx_q : row_dec[COL_W-1:0];
  assign rd_col  = stack_q[rd_addr];

  assign tg_row  = cmd_i.place ? row_q[COL_W-1:0] : row_dec[COL_W-1:0];
  assign tg_col  = cmd_i.place ? pick : rd_col;
  assign tg_dsum = SUM_W'(tg_row) + SUM_W'(size_q) - SUM_W'(1) - SUM_W'(tg_col);
  assign tg_usum = SUM_W'(tg_row) + SUM_W'(tg_col);

  assign emit_last = ((SIZE_W'(eidx_q) + SIZE_W'(1)) == size_q);

  always_comb begin
    row_d   = row_q;
    start_d = start_q;
    used_d  = used_q;
    down_d  = down_q;
    up_d    = up_q;
    if (cmd_i.load) begin
      row_d   = '0;
      start_d = '0;
      used_d  = '0;
      down_d  = '0;
      up_d    = '0;
    end else if (cmd_i.place || cmd_i.back) begin
      used_d[tg_col]               = !used_q[tg_col];
      down_d[tg_dsum[DIAG_IW-1:0]] = !down_q[tg_dsum[DIAG_IW-1:0]];
      up_d[tg_usum[DIAG_IW-1:0]]   = !up_q[tg_usum[DIAG_IW-1:0]];
      if (cmd_i.place) begin
        row_d   = row_q + SIZE_W'(1);
        start_d = '0;
      end else begin
        row_d   = row_dec;
        start_d = SIZE_W'(rd_col) + SIZE_W'(1);
      end
    end
  end

  assign stat_o.size_ok   = (size_q != '0) && (size_q <= SIZE_W'(MAX_SIZE));
  assign stat_o.row_full  = (row_q == size_q);
  assign stat_o.hit       = |free_v;
  assign stat_o.row_zero  = (row_q == '0);
  assign stat_o.emit_last = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      start_q <= '0;
      used_q  <= '0;
      down_q  <= '0;
      up_q    <= '0;
      eidx_q  <= '0;
    end else begin
      row_q   <= row_d;
      start_q <= start_d;
      used_q  <= used_d;
      down_q  <= down_d;
      up_q    <= up_d;
      if (cmd_i.load) begin
        eidx_q <= '0;
      end else if (cmd_i.emit_row) begin
        eidx_q <= eidx_q + COL_W'(1);
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q <= board_size_i;
    end
    if (cmd_i.place) begin
      stack_q[row_q[COL_W-1:0]] <= pick;
    end
    if (cmd_i.emit_row) begin
      found_o        <= 1'b1;
      row_index_o    <= eidx_q;
      queen_column_o <= rd_col;
      last_o         <= emit_last;
    end else if (cmd_i.emit_fail) begin
      found_o        <= 1'b0;
      row_index_o    <= '0;
      queen_column_o <= '0;
      last_o         <= 1'b1;
    end
  end

endmodule
`default_nettype wire
